// ===== rtl/tdbc_pkg.sv =====
`timescale 1ns / 1ps

package tdbc_pkg;

  localparam logic [31:0] CK_INIT = 32'hFFFF_FFFF;
  localparam int unsigned ROM_DEPTH = 256;
  localparam int unsigned KEY_COUNT = 8;

  typedef logic [31:0] word_t;
  typedef word_t rom_t [ROM_DEPTH];
  typedef word_t keys_t [KEY_COUNT];

  localparam keys_t MIX_KEYS = '{
    32'h6E45_23B1, 32'hE2C5_AB89, 32'h98BA_75FE, 32'h1A32_547C,
    32'h68F5_21A4, 32'hD390_B674, 32'h95A2_65FC, 32'h5729_B1ED
  };

  // one table word: eight mixing rounds, keys taken from the top down
  function automatic word_t rom_entry(input int unsigned idx);
    word_t e;
    word_t a;
    word_t b;
    word_t c;
    word_t key;
    word_t idx_w;
    logic [4:0] sh;
    e = word_t'(idx);
    idx_w = word_t'(idx);
    sh = idx_w[4:0];
    for (int k = KEY_COUNT - 1; k >= 0; k--) begin
      key = MIX_KEYS[k];
      a = (e >> sh) ^ key;
      b = (word_t'(k) << sh) ^ key;
      c = word_t'(idx_w * key);
      e = e + a + b + c;
    end
    return e;
  endfunction

  function automatic rom_t build_rom();
    rom_t r;
    for (int unsigned i = 0; i < ROM_DEPTH; i++) begin
      r[i] = rom_entry(i);
    end
    return r;
  endfunction

  localparam rom_t CK_ROM = build_rom();

endpackage

// ===== rtl/tdbc_update.sv =====
`timescale 1ns / 1ps

module tdbc_update (
  input  tdbc_pkg::word_t  value,
  input  logic             restart,
  input  logic [7:0]       data_byte,
  output tdbc_pkg::word_t  value_next
);
  import tdbc_pkg::*;

  word_t base;

  always_comb begin
    base = restart ? CK_INIT : value;
    value_next = (base >> 8) ^ CK_ROM[data_byte ^ base[7:0]];
  end

endmodule

// ===== rtl/table_driven_byte_checksum32_top.sv =====
`timescale 1ns / 1ps
// a result is registered in the output buffer when its byte is accepted
// throughput: one byte per cycle while s_tready is high; the chain through
// the table lookup and the running-value register sets this figure
// a two-entry output buffer keeps s_tready high for one stalled result
// reset (rst, synchronous) empties the output buffer and loads the running value
// with all ones

module table_driven_byte_checksum32_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] first_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] checksum
  output logic        m_tlast    // done_res
);
  import tdbc_pkg::*;

  word_t running;
  word_t running_next;
  logic  s_fire;

  logic  out_valid;
  word_t out_sum;
  logic  out_last;
  logic  skid_valid;
  word_t skid_sum;
  logic  skid_last;

  tdbc_update u_update (
    .value      (running),
    .restart    (s_tuser),
    .data_byte  (s_tdata),
    .value_next (running_next)
  );

  assign s_tready = !skid_valid;
  assign s_fire   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= CK_INIT;
    end else if (s_fire) begin
      running <= running_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      // no transaction is taken while the skid entry is full
      if (m_tready) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (s_fire) begin
      if (!out_valid || m_tready) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (m_tready) begin
        out_sum  <= skid_sum;
        out_last <= skid_last;
      end
    end else if (s_fire) begin
      if (!out_valid || m_tready) begin
        out_sum  <= running_next;
        out_last <= s_tlast;
      end else begin
        skid_sum  <= running_next;
        skid_last <= s_tlast;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_sum;
  assign m_tlast  = out_last;

endmodule

// ===== test/checksum_monitor.sv =====
`timescale 1ns / 1ps

module checksum_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);

  localparam logic [31:0] SEED_VALUE = 32'hFFFF_FFFF;
  localparam logic [31:0] ROUND_KEYS [8] = '{
    32'h6E45_23B1, 32'hE2C5_AB89, 32'h98BA_75FE, 32'h1A32_547C,
    32'h68F5_21A4, 32'hD390_B674, 32'h95A2_65FC, 32'h5729_B1ED
  };

  typedef struct packed {
    logic [31:0] sum;
    logic        done;
  } checksum_t;

  logic [31:0] lookup_words [256];
  logic [31:0] chain_value;
  checksum_t   checksum_q [$];
  checksum_t   want;

  // eight rounds per word, keys walked from the top down, shift amount is idx mod 32
  function automatic logic [31:0] lookup_word(input int unsigned idx);
    logic [31:0] acc;
    logic [31:0] key;
    logic [31:0] idx_w;
    int unsigned rot;
    idx_w = idx;
    acc = idx_w;
    rot = idx % 32;
    for (int r = 7; r >= 0; r--) begin
      key = ROUND_KEYS[r];
      acc = acc + ((acc >> rot) ^ key) + ((32'(r) << rot) ^ key) + 32'(idx_w * key);
    end
    return acc;
  endfunction

  initial begin
    for (int i = 0; i < 256; i++) begin
      lookup_words[i] = lookup_word(i);
    end
    chain_value = SEED_VALUE;
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      chain_value = SEED_VALUE;
      checksum_q.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          chain_value = SEED_VALUE;
        end
        chain_value = (chain_value >> 8) ^ lookup_words[s_tdata ^ chain_value[7:0]];
        checksum_q.push_back('{sum: chain_value, done: s_tlast});
      end
      // a result never leaves on the edge its own byte enters, so fifo order holds
      if (m_tvalid && m_tready) begin
        if (checksum_q.size() == 0) begin
          $display("%0t: unexpected result transaction, checksum %h last %b",
                   $time, m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = checksum_q.pop_front();
          if (m_tdata !== want.sum) begin
            $display("%0t: checksum mismatch: expected %h, got %h", $time, want.sum, m_tdata);
            fail_count++;
          end
          if (m_tlast !== want.done) begin
            $display("%0t: tlast mismatch: expected %b, got %b", $time, want.done, m_tlast);
            fail_count++;
          end
        end
      end
    end
    pending = checksum_q.size();
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_BYTES = 1950;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  always #5 clk = ~clk;

  table_driven_byte_checksum32_top DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  checksum_monitor u_monitor (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // mostly back to back, some short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (calm) begin
      stall_left = 0;
      m_tready = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
      stall_left = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("table_driven_byte_checksum32_top test failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
    int gap;
    gap = calm ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = data;
    s_tuser = first;
    s_tlast = last;
    do @(posedge clk); while (!s_tready);
  endtask

  initial begin
    int sent;
    int len;
    bit noisy;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // chain from the reset value without a first flag
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    // a byte after a last byte keeps chaining
    send_byte(8'h12, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1);
    // one-byte buffers
    send_byte(8'hAA, 1'b1, 1'b1);
    send_byte(8'h55, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    // ordinary buffer
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'hFE, 1'b0, 1'b1);
    // restart in the middle with no last byte before it
    send_byte(8'h3C, 1'b1, 1'b0);
    send_byte(8'hC3, 1'b0, 1'b0);
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);

    sent = 0;
    while (sent < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        calm = ~calm;
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
      noisy = ($urandom_range(0, 99) < 15);
      for (int j = 0; j < len; j++) begin
        if (noisy) begin
          send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end else begin
          send_byte(8'($urandom_range(0, 255)), j == 0, j == len - 1);
        end
      end
      sent += len;
    end

    @(negedge clk);
    s_tvalid = 1'b0;
    calm = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("table_driven_byte_checksum32_top test passed");
    end else begin
      $display("table_driven_byte_checksum32_top test failed");
    end
    $finish;
  end

endmodule
